>>> hw/rtl/ndpc_pkg.sv
package ndpc_pkg;

  // Fixed field widths
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned DIM_CNT_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_EXTENTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_EXTENTS  = 2'd2;

  // Reset values
  localparam logic [DIM_CNT_W-1:0] DIM_COUNT_RST = 3'd1;
  localparam logic [CFG_W-1:0]     EXTENTS_RST   = 32'h0101_0101;

  // Controller -> datapath
  typedef struct packed {
    logic start;   // word accepted: clear/init accumulators and counters
    logic step;    // one dimension of multiply-accumulate
    logic finish;  // load output register, advance odometer
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic k_zero;  // current step is the last dimension (dim 0)
  } sts_t;

endpackage

>>> hw/rtl/nd_array_pad_copy_address_gen.sv
// Address generator for an N-dimensional crop/pad copy: each input word
// (restart bit) yields one word holding the row-major source offset, the
// destination offset and a last flag, walking the index region shared by
// both arrays with the last dimension fastest and wrapping to zero after
// the last element. Each item runs a load step, then a step for each
// active dimension (clamped dim_count of 1..MAX_DIMS) through the shared
// multiply-accumulate unit of each array, then a step that loads the output
// register once it is free and steps the odometer, before the next accept.
// The output register lets a new word be accepted while a result waits.
// Configuration is written through a port that is always ready; writes are
// only meant to land while no word is in flight.
module nd_array_pad_copy_address_gen
  import ndpc_pkg::*;
#(
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned EXTENT_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 restart_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OFF_W-1:0]     src_offset_o,
  output logic [OFF_W-1:0]     dst_offset_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;

  // config writes take effect immediately
  assign cfg_ready_o = 1'b1;

  ndpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ndpc_dp #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .restart_i    (restart_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .src_offset_o (src_offset_o),
    .dst_offset_o (dst_offset_o),
    .last_o       (last_o)
  );

  // Never load the output register over a word not yet taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || out_ready_i))
    else $error("output word overwritten");

  // One word in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted while busy");

  // Controller issues at most one command per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.step, cmd.finish}))
    else $error("conflicting datapath commands");

  // A finish is always followed by a valid output word
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished word not presented");

endmodule

>>> hw/rtl/ndpc_ctrl.sv
module ndpc_ctrl
  import ndpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (sts_i.k_zero) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/ndpc_dp.sv
module ndpc_dp
  import ndpc_pkg::*;
#(
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned EXTENT_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 restart_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [OFF_W-1:0]     src_offset_o,
  output logic [OFF_W-1:0]     dst_offset_o,
  output logic                 last_o
);

  localparam int unsigned IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int unsigned PAD_W  = OFF_W - EXTENT_BITS;

  // Configuration
  logic [DIM_CNT_W-1:0] dim_count_q;
  logic [CFG_W-1:0]     src_ext_q, dst_ext_q;

  // Walk state
  logic [EXTENT_BITS-1:0] cnt_q [MAX_DIMS];
  logic [EXTENT_BITS-1:0] cnt_d [MAX_DIMS];
  logic [IDX_W-1:0]       k_q, k_d;
  logic [OFF_W-1:0]       src_acc_q, src_acc_d, dst_acc_q, dst_acc_d;
  logic [OFF_W-1:0]       src_str_q, src_str_d, dst_str_q, dst_str_d;
  logic [OFF_W-1:0]       src_off_q, dst_off_q;
  logic                   last_q;

  logic [DCNT_W-1:0]      act;
  logic [EXTENT_BITS-1:0] se [MAX_DIMS];
  logic [EXTENT_BITS-1:0] de [MAX_DIMS];
  logic [EXTENT_BITS-1:0] lim [MAX_DIMS];
  logic [EXTENT_BITS-1:0] cnt_adv [MAX_DIMS];
  logic                   all_end;
  logic [OFF_W-1:0]       c_ext, se_ext, de_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= DIM_COUNT_RST;
      src_ext_q   <= EXTENTS_RST;
      dst_ext_q   <= EXTENTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIM_COUNT:   dim_count_q <= cfg_data_i[DIM_CNT_W-1:0];
        CFG_SRC_EXTENTS: src_ext_q   <= cfg_data_i;
        CFG_DST_EXTENTS: dst_ext_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Active dimension count, clamped to 1..MAX_DIMS
  always_comb begin
    if (dim_count_q == '0) begin
      act = DCNT_W'(1);
    end else if (32'(dim_count_q) > MAX_DIMS) begin
      act = DCNT_W'(MAX_DIMS);
    end else begin
      act = DCNT_W'(dim_count_q);
    end
  end

  // Per-dimension extents and shared-region limits; zero reads as one,
  // a field that starts past the register reads as one
  always_comb begin
    logic [CFG_W-1:0] sh_s, sh_d;
    sh_s = '0;
    sh_d = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (i * EXTENT_BITS >= CFG_W) begin
        se[i] = EXTENT_BITS'(1);
        de[i] = EXTENT_BITS'(1);
      end else begin
        sh_s  = src_ext_q >> (i * EXTENT_BITS);
        sh_d  = dst_ext_q >> (i * EXTENT_BITS);
        se[i] = (sh_s[EXTENT_BITS-1:0] == '0) ? EXTENT_BITS'(1) : sh_s[EXTENT_BITS-1:0];
        de[i] = (sh_d[EXTENT_BITS-1:0] == '0) ? EXTENT_BITS'(1) : sh_d[EXTENT_BITS-1:0];
      end
      lim[i] = ((se[i] < de[i]) ? se[i] : de[i]) - EXTENT_BITS'(1);
    end
  end

  // Last flag and odometer advance (last dimension fastest)
  always_comb begin
    logic carry;
    carry   = 1'b1;
    all_end = 1'b1;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      cnt_adv[i] = cnt_q[i];
      if (i < int'(act)) begin
        if (cnt_q[i] < lim[i]) begin
          all_end = 1'b0;
        end
        if (carry) begin
          if (cnt_q[i] < lim[i]) begin
            cnt_adv[i] = cnt_q[i] + EXTENT_BITS'(1);
            carry      = 1'b0;
          end else begin
            cnt_adv[i] = '0;
          end
        end
      end
    end
  end

  // One dimension per step: offset += index * stride, stride *= extent
  assign c_ext  = {{PAD_W{1'b0}}, cnt_q[k_q]};
  assign se_ext = {{PAD_W{1'b0}}, se[k_q]};
  assign de_ext = {{PAD_W{1'b0}}, de[k_q]};

  always_comb begin
    k_d       = k_q;
    src_acc_d = src_acc_q;
    dst_acc_d = dst_acc_q;
    src_str_d = src_str_q;
    dst_str_d = dst_str_q;
    for (int i = 0; i < MAX_DIMS; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    priority if (cmd_i.start) begin
      k_d       = IDX_W'(act - DCNT_W'(1));
      src_acc_d = '0;
      dst_acc_d = '0;
      src_str_d = OFF_W'(1);
      dst_str_d = OFF_W'(1);
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (restart_i || i >= int'(act)) begin
          cnt_d[i] = '0;
        end
      end
    end else if (cmd_i.step) begin
      k_d       = k_q - IDX_W'(1);
      src_acc_d = src_acc_q + c_ext * src_str_q;
      dst_acc_d = dst_acc_q + c_ext * dst_str_q;
      src_str_d = src_str_q * se_ext;
      dst_str_d = dst_str_q * de_ext;
    end else if (cmd_i.finish) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        cnt_d[i] = cnt_adv[i];
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    src_acc_q <= src_acc_d;
    dst_acc_q <= dst_acc_d;
    src_str_q <= src_str_d;
    dst_str_q <= dst_str_d;
    if (cmd_i.finish) begin
      src_off_q <= src_acc_q;
      dst_off_q <= dst_acc_q;
      last_q    <= all_end;
    end
  end

  assign sts_o.k_zero = (k_q == '0);
  assign src_offset_o = src_off_q;
  assign dst_offset_o = dst_off_q;
  assign last_o       = last_q;

endmodule

>>> test/tb_nd_array_pad_copy_address_gen.sv
`timescale 1ns / 100ps

module tb_nd_array_pad_copy_address_gen;
  import ndpc_pkg::*;

  localparam int unsigned MAX_DIMS    = 4;
  localparam int unsigned EXTENT_BITS = 8;
  // Worst case is far below this, sender gaps and receiver stalls included,
  // for at most 2419 words.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OFF_W-1:0] src;
    logic [OFF_W-1:0] dst;
    logic             last;
  } addr_pair_t;

  // Receiver behavior, reselected whenever sink_cycle[6:0] is zero
  typedef enum logic [1:0] {
    SINK_OPEN,    // always ready
    SINK_RANDOM,  // ready on three draws out of four on average
    SINK_PULSED   // stalled and ready in turn, following sink_cycle[3]
  } sink_mode_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_DIM_COUNT;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 restart_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [OFF_W-1:0]     src_offset_o;
  logic [OFF_W-1:0]     dst_offset_o;
  logic                 last_o;

  nd_array_pad_copy_address_gen #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .src_offset_o (src_offset_o),
    .dst_offset_o (dst_offset_o),
    .last_o       (last_o)
  );

  // Restart bits waiting to be sent, and address pairs waiting to come out
  bit         pending_restarts[$];
  addr_pair_t pending_pairs[$];

  int errors = 0;

  // Shadow of the configuration and of the odometer
  logic [DIM_CNT_W-1:0]   dims_reg    = DIM_COUNT_RST;
  logic [CFG_W-1:0]       src_ext_reg = EXTENTS_RST;
  logic [CFG_W-1:0]       dst_ext_reg = EXTENTS_RST;
  logic [EXTENT_BITS-1:0] walk_idx[MAX_DIMS];

  initial begin
    for (int i = 0; i < MAX_DIMS; i++) walk_idx[i] = '0;
  end

  // One tick of the odometer: offsets of the current index, then advance.
  // Last dimension moves fastest; zero extents count as one.
  function automatic addr_pair_t advance_walk(input logic restart);
    int                     d;
    logic [OFF_W-1:0]       s_stride;
    logic [OFF_W-1:0]       d_stride;
    logic [OFF_W-1:0]       s_ext;
    logic [OFF_W-1:0]       d_ext;
    logic [EXTENT_BITS-1:0] lim[MAX_DIMS];
    addr_pair_t             p;
    d = (dims_reg == 0) ? 1 : ((dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg));
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (restart || i >= d) walk_idx[i] = '0;
    end
    p.src    = '0;
    p.dst    = '0;
    p.last   = 1'b1;
    s_stride = 1;
    d_stride = 1;
    for (int k = d - 1; k >= 0; k--) begin
      s_ext = OFF_W'(src_ext_reg[EXTENT_BITS*k +: EXTENT_BITS]);
      d_ext = OFF_W'(dst_ext_reg[EXTENT_BITS*k +: EXTENT_BITS]);
      if (s_ext == 0) s_ext = 1;
      if (d_ext == 0) d_ext = 1;
      lim[k]   = EXTENT_BITS'(((s_ext < d_ext) ? s_ext : d_ext) - 1);
      p.src    = p.src + OFF_W'(walk_idx[k]) * s_stride;
      p.dst    = p.dst + OFF_W'(walk_idx[k]) * d_stride;
      s_stride = s_stride * s_ext;
      d_stride = d_stride * d_ext;
      // a counter already past the shared end counts as finished
      if (walk_idx[k] < lim[k]) p.last = 1'b0;
    end
    for (int k = d - 1; k >= 0; k--) begin
      if (walk_idx[k] < lim[k]) begin
        walk_idx[k] = walk_idx[k] + 1'b1;
        break;
      end
      walk_idx[k] = '0;
    end
    return p;
  endfunction

  // Extents are mostly tiny so that walks finish often; now and then a
  // byte, or the whole register, is fully random.
  function automatic logic [CFG_W-1:0] pick_extents();
    logic [CFG_W-1:0] v;
    if ($urandom_range(0, 7) == 0) return $urandom();
    for (int i = 0; i < CFG_W / EXTENT_BITS; i++) begin
      v[EXTENT_BITS*i +: EXTENT_BITS] = ($urandom_range(0, 5) == 0) ?
          EXTENT_BITS'($urandom_range(0, 255)) : EXTENT_BITS'($urandom_range(0, 3));
    end
    return v;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: bursts of random length, random gaps in between
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // accepted word: predict its address pair now, with the current config
      if (in_valid_i && in_ready_o) pending_pairs.push_back(advance_walk(restart_i));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || pending_restarts.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          restart_i  <= pending_restarts.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Receiver: checks each accepted word against the oldest prediction
  sink_mode_e  sink_mode = SINK_OPEN;
  logic [15:0] sink_cycle;
  addr_pair_t  want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_mode   <= SINK_OPEN;
      sink_cycle  <= '0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_pairs.size() == 0) begin
          errors++;
          $display("%0t: unexpected word src=%h dst=%h last=%b",
                   $time, src_offset_o, dst_offset_o, last_o);
        end else begin
          want = pending_pairs.pop_front();
          if (src_offset_o !== want.src) begin
            errors++;
            $display("%0t: src_offset expected %h actual %h", $time, want.src, src_offset_o);
          end
          if (dst_offset_o !== want.dst) begin
            errors++;
            $display("%0t: dst_offset expected %h actual %h", $time, want.dst, dst_offset_o);
          end
          if (last_o !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          end
        end
      end
      sink_cycle <= sink_cycle + 1'b1;
      if (sink_cycle[6:0] == '0) sink_mode <= sink_mode_e'($urandom_range(0, 2));
      case (sink_mode)
        SINK_OPEN:   out_ready_i <= 1'b1;
        SINK_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:     out_ready_i <= sink_cycle[3];
      endcase
    end
  end

  // Watchdog
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Block until every queued word went in and every pair came back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_restarts.size() != 0 || in_valid_i || pending_pairs.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DIM_COUNT:   dims_reg    = data[DIM_CNT_W-1:0];
      CFG_SRC_EXTENTS: src_ext_reg = data;
      CFG_DST_EXTENTS: dst_ext_reg = data;
      default: ;
    endcase
  endtask

  // New geometry, only once the block is idle. Odometer is not restarted,
  // so a shrink leaves counters beyond the new region.
  task automatic load_setup(input logic [DIM_CNT_W-1:0] dims,
                            input logic [CFG_W-1:0] src_ext,
                            input logic [CFG_W-1:0] dst_ext);
    drain();
    write_reg(CFG_DIM_COUNT, CFG_W'(dims));
    write_reg(CFG_SRC_EXTENTS, src_ext);
    write_reg(CFG_DST_EXTENTS, dst_ext);
    @(negedge clk_i);
  endtask

  initial begin
    int n_words;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset geometry: a single element, every word is last
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);

    // 2-D walk, 2x2 shared region, run past the wrap and stop mid-walk
    load_setup(3'd2, 32'h0000_0203, 32'h0000_0402);
    pending_restarts.push_back(1'b1);
    repeat (6) pending_restarts.push_back(1'b0);

    // shrink to zero extents (read as one) with counters left beyond the end
    load_setup(3'd2, 32'h0000_0000, 32'h0000_0000);
    repeat (2) pending_restarts.push_back(1'b0);

    // zero dimension count acts as one; upper counters forced to zero
    load_setup(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) pending_restarts.push_back(1'b0);

    // oversized dimension count saturates; large source, mixed destination
    load_setup(3'd7, 32'hFFFF_FFFF, 32'hFF00_FF00);
    pending_restarts.push_back(1'b1);
    repeat (3) pending_restarts.push_back(1'b0);

    // random geometries, mostly uninterrupted walks with an occasional restart
    repeat (20) begin
      load_setup(DIM_CNT_W'($urandom_range(0, 7)), pick_extents(), pick_extents());
      n_words = $urandom_range(60, 120);
      repeat (n_words) pending_restarts.push_back($urandom_range(0, 19) == 0);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (pending_pairs.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, pending_pairs.size());
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
